FILE: rtl/aes128_cbc_cipher_unit_macros.svh
// ----------------------------------------------------------------------------
// AES-128 CBC cipher unit assertion macros
// Concurrent check wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef AES128_CBC_CIPHER_UNIT_MACROS_SVH
`define AES128_CBC_CIPHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ACU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ACU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ACU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ACU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/acu_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 CBC cipher unit package
// S-boxes, round functions and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package acu_pkg;

   localparam int ROUNDS_DEFAULT = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HI = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IV_HI  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IV_LO  = 2'd3;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef struct packed {
      logic start;
      logic decrypt;
   } core_ctl_type;

   localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   function automatic logic [7:0] xt(input logic [7:0] x);
      xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits in bits 127-8i downto 120-8i
   function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
      get_b = s[127-8*i -: 8];
   endfunction

   function automatic logic [127:0] fwd_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*c+r) -: 8] = FWD_BOX[get_b(s, 4*((c+r)%4)+r)];
         end
      end
      fwd_sub_shift = t;
   endfunction

   function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*((c+r)%4)+r) -: 8] = INV_BOX[get_b(s, 4*c+r)];
         end
      end
      inv_sub_shift = t;
   endfunction

   function automatic logic [127:0] fwd_mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_b(s, 4*c); a1 = get_b(s, 4*c+1);
         a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
         t[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
         t[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
         t[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
         t[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
      fwd_mix = t;
   endfunction

   // inverse mix as forward mix after a preconditioning step
   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3, u, v;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_b(s, 4*c); a1 = get_b(s, 4*c+1);
         a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
         u = xt(xt(a0 ^ a2));
         v = xt(xt(a1 ^ a3));
         t[127-8*(4*c)   -: 8] = a0 ^ u;
         t[127-8*(4*c+1) -: 8] = a1 ^ v;
         t[127-8*(4*c+2) -: 8] = a2 ^ u;
         t[127-8*(4*c+3) -: 8] = a3 ^ v;
      end
      inv_mix = fwd_mix(t);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/acu_key_expand.sv
// ----------------------------------------------------------------------------
// AES-128 key schedule
// Expands the cipher key one round key per cycle into a round key memory.
// ----------------------------------------------------------------------------
`default_nettype none
module acu_key_expand #(
   parameter int ROUNDS = acu_pkg::ROUNDS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [127:0]                      key,
   input  wire logic [$clog2(ROUNDS+1)-1:0]       rd_addr,
   output logic      [127:0]                      rd_data,
   output logic                                   busy
);
   localparam int RK_W = $clog2(ROUNDS+1);

   logic [127:0] mem [ROUNDS+1];
   logic [127:0] cur_ff, cur_in;
   logic [7:0]   rc_ff, rc_in;
   logic [RK_W-1:0] idx_ff, idx_in;
   logic         busy_ff, busy_in;
   logic [31:0]  t;
   logic [31:0]  w0, w1, w2, w3;

   always_comb begin
      t = {acu_pkg::FWD_BOX[cur_ff[23:16]], acu_pkg::FWD_BOX[cur_ff[15:8]],
           acu_pkg::FWD_BOX[cur_ff[7:0]], acu_pkg::FWD_BOX[cur_ff[31:24]]}
          ^ {rc_ff, 24'h0};
      w0 = cur_ff[127:96] ^ t;
      w1 = cur_ff[95:64] ^ w0;
      w2 = cur_ff[63:32] ^ w1;
      w3 = cur_ff[31:0] ^ w2;
      cur_in  = cur_ff;
      rc_in   = rc_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (start) begin
         cur_in  = key;
         rc_in   = 8'h01;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cur_in = {w0, w1, w2, w3};
         rc_in  = acu_pkg::xt(rc_ff);
         idx_in = idx_ff + 1'b1;
         if (idx_ff == RK_W'(ROUNDS)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         rc_ff   <= 8'h01;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         rc_ff   <= rc_in;
      end
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (busy_ff) mem[idx_ff] <= cur_ff;
      rd_data <= mem[rd_addr];
   end

   assign busy = busy_ff | start;
endmodule
`default_nettype wire

FILE: rtl/acu_round_core.sv
// ----------------------------------------------------------------------------
// AES-128 round datapath
// One shared round unit, forward or inverse, stepped by a round counter.
// ----------------------------------------------------------------------------
`default_nettype none
module acu_round_core #(
   parameter int ROUNDS = acu_pkg::ROUNDS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire acu_pkg::core_ctl_type       ctl,
   input  wire logic [127:0]                block,
   input  wire logic [127:0]                rk_data,
   output logic      [$clog2(ROUNDS+1)-1:0] rk_addr,
   output logic      [127:0]                state,
   output logic                             done
);
   localparam int RK_W = $clog2(ROUNDS+1);

   typedef enum logic [1:0] {S_IDLE, S_FETCH, S_ROUND} state_type;

   state_type       fsm_ff, fsm_in;
   logic [RK_W-1:0] rnd_ff, rnd_in;
   logic [127:0]    st_ff, st_in;
   logic            dec_ff, dec_in;
   logic            done_ff, done_in;
   logic [127:0]    fs, is;
   logic            first, last;

   always_comb begin
      fsm_in  = fsm_ff;
      rnd_in  = rnd_ff;
      st_in   = st_ff;
      dec_in  = dec_ff;
      done_in = 1'b0;
      first   = (rnd_ff == '0);
      last    = (rnd_ff == RK_W'(ROUNDS+1));
      fs      = acu_pkg::fwd_sub_shift(st_ff);
      is      = acu_pkg::inv_sub_shift(st_ff);
      unique case (fsm_ff)
         S_IDLE: begin
            if (ctl.start) begin
               st_in  = block;
               dec_in = ctl.decrypt;
               rnd_in = '0;
               fsm_in = S_FETCH;
            end
         end
         S_FETCH: begin
            fsm_in = S_ROUND;
            rnd_in = rnd_ff + 1'b1;
         end
         S_ROUND: begin
            if (rnd_ff == RK_W'(1)) begin
               st_in = st_ff ^ rk_data;
            end else if (!dec_ff) begin
               st_in = last ? fs ^ rk_data : acu_pkg::fwd_mix(fs) ^ rk_data;
            end else begin
               st_in = last ? is ^ rk_data : acu_pkg::inv_mix(is ^ rk_data);
            end
            if (rnd_ff == RK_W'(ROUNDS+1)) begin
               fsm_in  = S_IDLE;
               done_in = 1'b1;
               rnd_in  = '0;
            end else begin
               rnd_in = rnd_ff + 1'b1;
            end
         end
         default: fsm_in = S_IDLE;
      endcase
   end

   // counter runs one ahead of the step it addresses (read latency)
   always_comb begin
      logic [RK_W-1:0] step;
      step = (fsm_ff == S_FETCH) ? '0 : rnd_ff;
      if (!dec_ff) rk_addr = step;
      else         rk_addr = RK_W'(ROUNDS) - step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff  <= S_IDLE;
         rnd_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         fsm_ff  <= fsm_in;
         rnd_ff  <= rnd_in;
         done_ff <= done_in;
      end
      st_ff  <= st_in;
      dec_ff <= dec_in;
   end

   assign state = st_ff;
   assign done  = done_ff;
endmodule
`default_nettype wire

FILE: rtl/aes128_cbc_cipher_unit.sv
// ----------------------------------------------------------------------------
// AES-128 CBC cipher unit
// Channel  Dir  Payload
// req      in   tdata {data_lo,data_hi}, tuser opcode|first_block<<1, tlast
// rsp      out  tdata {result_lo,result_hi}, tlast last_out
// csr      in   index 2b, data 64b
// rsp_tvalid rises after the key fetch, the round steps, the done register
// and the output register. Without stalls a block passes the key fetch,
// ROUNDS+1 round steps, done, output register, and then req_tready reopens.
// req_tready stays low after reset and after each key write until the keys expand.
// req_tready stays low while a block runs, the output is full or keys expand.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aes128_cbc_cipher_unit_macros.svh"
module aes128_cbc_cipher_unit #(
   parameter int ROUNDS = acu_pkg::ROUNDS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [127:0]                    req_tdata,  // data_lo, data_hi
   input  wire logic [1:0]                      req_tuser,  // first_block, opcode
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [127:0]                    rsp_tdata,  // result_lo, result_hi
   output logic                                 rsp_tlast,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [acu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [63:0]                     csr_data
);
   localparam int RK_W = $clog2(ROUNDS+1);

   logic [63:0]  key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] cin_ff;
   logic         dec_ff, last_ff, busy_ff;
   logic         kstart_ff;
   logic         rsp_v_ff;
   logic [127:0] rsp_d_ff;
   logic         rsp_l_ff;
   logic         kbusy, core_done;
   logic [RK_W-1:0] rk_addr;
   logic [127:0] rk_data, core_state, blk_in, chain_sel, data_in, res;
   logic         accept, key_wr;
   acu_pkg::core_ctl_type ctl;

   assign csr_ready  = 1'b1;
   assign key_wr     = csr_valid & ((csr_index == acu_pkg::CSR_KEY_HI) |
                                    (csr_index == acu_pkg::CSR_KEY_LO));
   assign req_tready = ~busy_ff & ~rsp_v_ff & ~kbusy & ~kstart_ff;
   assign accept     = req_tvalid & req_tready;
   assign data_in    = {req_tdata[63:0], req_tdata[127:64]};
   assign chain_sel  = req_tuser[1] ? {iv_hi_ff, iv_lo_ff} : chain_ff;
   assign blk_in     = (req_tuser[0] == acu_pkg::OP_DECRYPT) ? data_in
                                                              : data_in ^ chain_sel;
   assign ctl.start   = accept;
   assign ctl.decrypt = req_tuser[0];
   assign res = dec_ff ? core_state ^ cin_ff : core_state;

   always_comb begin
      chain_in = chain_ff;
      if (core_done) chain_in = dec_ff ? chain_ff : core_state;
      if (accept && req_tuser[0] == acu_pkg::OP_DECRYPT) chain_in = data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0; key_lo_ff <= '0; iv_hi_ff <= '0; iv_lo_ff <= '0;
         chain_ff  <= '0;
         busy_ff   <= 1'b0;
         kstart_ff <= 1'b1;
         rsp_v_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               acu_pkg::CSR_KEY_HI: key_hi_ff <= csr_data;
               acu_pkg::CSR_KEY_LO: key_lo_ff <= csr_data;
               acu_pkg::CSR_IV_HI:  iv_hi_ff  <= csr_data;
               acu_pkg::CSR_IV_LO:  iv_lo_ff  <= csr_data;
               default: ;
            endcase
         end
         kstart_ff <= key_wr;
         chain_ff  <= chain_in;
         if (accept) busy_ff <= 1'b1;
         else if (core_done) busy_ff <= 1'b0;
         if (core_done) rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
      end
      if (accept) begin
         cin_ff  <= chain_sel;
         dec_ff  <= req_tuser[0];
         last_ff <= req_tlast;
      end
      if (core_done) begin
         rsp_d_ff <= res;
         rsp_l_ff <= last_ff;
      end
   end

   acu_key_expand #(.ROUNDS(ROUNDS)) u_key (
      .clock, .reset, .start(kstart_ff), .key({key_hi_ff, key_lo_ff}),
      .rd_addr(rk_addr), .rd_data(rk_data), .busy(kbusy)
   );

   acu_round_core #(.ROUNDS(ROUNDS)) u_core (
      .clock, .reset, .ctl, .block(blk_in), .rk_data, .rk_addr,
      .state(core_state), .done(core_done)
   );

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {rsp_d_ff[63:0], rsp_d_ff[127:64]};
   assign rsp_tlast  = rsp_l_ff;

   `ACU_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff)
   `ACU_ASSERT_IMPL(a_done_slot, clock, reset, core_done, busy_ff && !rsp_v_ff)
   `ACU_ASSERT_IMPL(a_no_accept_keys, clock, reset, kbusy, !accept)
endmodule
`default_nettype wire
